FILE: design/mbb_pkg.sv
// Shared constants, types and widths for the mesh bounding box centre and radius unit.
`default_nettype none
package mbb_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_AXES   = 3;

  // Sum of three squared extents, and its floor square root.
  localparam int SUM_W      = 2 * COORD_BITS + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int ROOT_ITERS = SUM_W / 2;
  localparam int ITER_W     = $clog2(ROOT_ITERS + 1);

  localparam int IN_DATA_W  = ((NUM_AXES * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = (((NUM_AXES + 1) * COORD_BITS + 7) / 8) * 8;

  localparam logic [COORD_BITS-1:0] RAD_EMPTY = COORD_BITS'(64'd1 << FRAC_BITS);
  localparam logic [COORD_BITS-1:0] RAD_MIN   = COORD_BITS'((64'd1 << FRAC_BITS) >> 1);

  typedef struct packed {
    logic [COORD_BITS-1:0]        extent;
    logic signed [COORD_BITS-1:0] center;
  } lane_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [COORD_BITS-1:0]        radius;
    logic                         was_empty;
  } mbb_result_t;

endpackage
`default_nettype wire

FILE: design/mbb_lane.sv
// One axis lane: running minimum and maximum, with extent and centre of the box.
`default_nettype none
module mbb_lane
  import mbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic                  first,
  input  wire logic                  clear,
  input  wire logic [COORD_BITS-1:0] value,
  output lane_out_t                  lane_out
);

  logic signed [COORD_BITS-1:0] low;
  logic signed [COORD_BITS-1:0] high;
  logic [COORD_BITS:0]          sum;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      low  <= '0;
      high <= '0;
    end else if (take) begin
      if (first || ($signed(value) < low)) begin
        low <= $signed(value);
      end
      if (first || ($signed(value) > high)) begin
        high <= $signed(value);
      end
    end
  end

  // The difference of the bounds never exceeds the unsigned range, so a wrap-around
  // subtraction gives the extent exactly.
  assign sum             = {high[COORD_BITS-1], high} + {low[COORD_BITS-1], low};
  assign lane_out.extent = COORD_BITS'(high - low);
  assign lane_out.center = $signed(sum[COORD_BITS:1]);

endmodule
`default_nettype wire

FILE: design/mbb_merge.sv
// Merging stage: sum of squared extents, digit-by-digit square root and result register.
`default_nettype none
module mbb_merge
  import mbb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        seen,
  input  wire lane_out_t   lane_x,
  input  wire lane_out_t   lane_y,
  input  wire lane_out_t   lane_z,
  output logic             busy,
  output mbb_result_t      out_res,
  output logic             out_valid,
  input  wire logic        out_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]              state;
  logic [ITER_W-1:0]       cnt;
  logic [COORD_BITS-1:0]   ext0;
  logic [COORD_BITS-1:0]   ext1;
  logic [COORD_BITS-1:0]   ext2;
  logic [2*COORD_BITS-1:0] prod;
  logic [SUM_W-1:0]        acc;
  logic [ROOT_W:0]         rem;
  logic [ROOT_W-1:0]       root;
  mbb_result_t             res;

  logic [ROOT_W+1:0]       rem_sh;
  logic [ROOT_W+1:0]       trial;
  logic [ROOT_W+1:0]       rem_diff;
  logic                    fits;
  logic [COORD_BITS-1:0]   rad_half;
  logic [COORD_BITS-1:0]   rad_final;
  logic                    out_free;

  // Each step brings down the next two bits of the sum and tries to set one root bit.
  assign rem_sh    = {rem[ROOT_W-1:0], acc[SUM_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign fits      = (rem_sh >= trial);
  assign rem_diff  = rem_sh - trial;
  assign rad_half  = root[ROOT_W-1:1];
  assign rad_final = res.was_empty ? RAD_EMPTY :
                     ((rad_half < RAD_MIN) ? RAD_MIN : rad_half);
  assign out_free  = !out_valid || out_ready;
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            ext0          <= lane_x.extent;
            ext1          <= lane_y.extent;
            ext2          <= lane_z.extent;
            acc           <= '0;
            rem           <= '0;
            root          <= '0;
            cnt           <= '0;
            res.was_empty <= !seen;
            res.center_x  <= seen ? lane_x.center : '0;
            res.center_y  <= seen ? lane_y.center : '0;
            res.center_z  <= seen ? lane_z.center : '0;
            res.radius    <= '0;
            state         <= seen ? ST_SQ : ST_OUT;
          end
        end
        ST_SQ: begin
          // One shared multiplier; the product is registered before it is summed.
          if (cnt < ITER_W'(NUM_AXES)) begin
            prod <= ext0 * ext0;
            ext0 <= ext1;
            ext1 <= ext2;
          end
          if (cnt != '0) begin
            acc <= acc + SUM_W'(prod);
          end
          if (cnt == ITER_W'(NUM_AXES)) begin
            cnt   <= '0;
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROOT: begin
          acc <= {acc[SUM_W-3:0], 2'b00};
          if (fits) begin
            rem  <= rem_diff[ROOT_W:0];
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[ROOT_W:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          if (cnt == ITER_W'(ROOT_ITERS - 1)) begin
            state <= ST_OUT;
          end
          cnt <= cnt + 1'b1;
        end
        ST_OUT: begin
          if (out_free) begin
            out_res.center_x  <= res.center_x;
            out_res.center_y  <= res.center_y;
            out_res.center_z  <= res.center_z;
            out_res.radius    <= rad_final;
            out_res.was_empty <= res.was_empty;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/mesh_bounding_box_center_radius_unit.sv
// Top level of the mesh bounding box centre and radius unit.
//
// Vertex beats arrive on the s_ channel: tdata carries x, y and z in signed
// Q16.16, tuser says whether the beat holds a vertex and tlast closes a mesh.
// Three axis lanes track the running minimum and maximum, one beat per cycle.
// The beat with tlast set is folded into the box when it holds a vertex, after
// which the lanes hand their extents and centres to the merging stage and clear
// for the next mesh. The merging stage squares the three extents on one shared
// multiplier and then takes the 33-bit floor square root one bit per cycle, and
// passes the result to the output register on m_. Vertex beats stream at one
// per cycle; after a closing beat s_tready stays low until the merging stage has
// passed its result to the output register, so the square root sets the spacing
// between meshes. An empty mesh gives centre zero, radius 1.0 and tuser set.
// The output register holds its beat while m_tready is low; vertex beats and the
// closing beat of the following mesh are still taken meanwhile, and its result
// then waits in the merging stage until the output register is free. Reset
// empties the box and drops any pending result.
`default_nettype none
module mesh_bounding_box_center_radius_unit
  import mbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // pos_x, pos_y, pos_z
  input  wire logic                  s_tuser,  // has_vertex
  input  wire logic                  s_tlast,  // last
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,  // center_x, center_y, center_z, radius
  output logic                       m_tuser   // was_empty
);

  logic        in_beat;
  logic        take;
  logic        seen_any;
  logic        finish;
  logic        merge_busy;
  lane_out_t   lane_x;
  lane_out_t   lane_y;
  lane_out_t   lane_z;
  mbb_result_t out_res;

  assign s_tready = !finish && !merge_busy;
  assign in_beat  = s_tvalid && s_tready;
  assign take     = in_beat && s_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any <= 1'b0;
      finish   <= 1'b0;
    end else begin
      finish <= in_beat && s_tlast;
      if (finish) begin
        seen_any <= 1'b0;
      end else if (take) begin
        seen_any <= 1'b1;
      end
    end
  end

  mbb_lane u_lane_x (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .first    (!seen_any),
    .clear    (finish),
    .value    (s_tdata[COORD_BITS-1:0]),
    .lane_out (lane_x)
  );

  mbb_lane u_lane_y (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .first    (!seen_any),
    .clear    (finish),
    .value    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .lane_out (lane_y)
  );

  mbb_lane u_lane_z (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .first    (!seen_any),
    .clear    (finish),
    .value    (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .lane_out (lane_z)
  );

  mbb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (finish),
    .seen      (seen_any),
    .lane_x    (lane_x),
    .lane_y    (lane_y),
    .lane_z    (lane_z),
    .busy      (merge_busy),
    .out_res   (out_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = OUT_DATA_W'({out_res.radius, out_res.center_z,
                                out_res.center_y, out_res.center_x});
  assign m_tuser = out_res.was_empty;

endmodule
`default_nettype wire

FILE: design/mbb_checker.sv
// Port-level checker for the mesh bounding box centre and radius unit, with its bind.
`default_nettype none
module mbb_checker
  import mbb_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  s_tlast,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser
);

  localparam logic [OUT_DATA_W-1:0] EMPTY_DATA =
    OUT_DATA_W'({RAD_EMPTY, {(NUM_AXES * COORD_BITS){1'b0}}});

  // A result beat that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == EMPTY_DATA)
    else $error("empty mesh result is not centre zero, radius one");

  a_radius_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[4*COORD_BITS-1:3*COORD_BITS] >= RAD_MIN)
    else $error("radius below one half");

  // The merging stage takes over the box in the cycle after a closing beat.
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken in the cycle after a closing beat");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mesh_bounding_box_center_radius_unit mbb_checker u_mbb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
